>>> hdl/two_link_ik_angle_solver_macros.svh
// Assertion macros for the angle solver RTL.
// Included by modules that carry concurrent checks; needs no package.
`ifndef TWO_LINK_IK_ANGLE_SOLVER_MACROS_SVH
`define TWO_LINK_IK_ANGLE_SOLVER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TLIK_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TLIK_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tlik_pkg.sv
// Shared constants, register indexes and the arctangent table of the angle solver.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tlik_pkg;

    // Number of CORDIC micro-rotations (8 to 24).
    localparam int CORDIC_STEPS = 16;
    // Datapath width of the CORDIC x and y registers.
    localparam int CORDIC_W     = 34;

    // Stage counts of the iterative units.
    localparam int DIST_STEPS   = 17;  // square root of a 34-bit sum, one bit per stage
    localparam int DIV_STEPS    = 28;  // cosine quotient bits
    localparam int SQ_STEPS     = 29;  // square root of a 57-bit value

    // Register stages inside the arccosine unit before its CORDIC.
    localparam int ACOS_PRE     = 1 + DIV_STEPS + 3 + SQ_STEPS;
    // Delay of the raw difference so the direction CORDIC lines up.
    localparam int THETA_DLY    = 22 + ACOS_PRE;
    // Total register stages from input beat to output register.
    localparam int PIPE_DEPTH   = 23 + ACOS_PRE + CORDIC_STEPS + 2;

    // Binary angles in units of 2^-32 turn.
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

    // Configuration register indexes.
    localparam logic REG_UPPER = 1'b0;
    localparam logic REG_LOWER = 1'b1;

    // atan(2^-i) in units of 2^-32 turn.
    function automatic logic [31:0] atan_entry(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/tlik_cordic.sv
// Pipelined vectoring CORDIC giving atan2(y, x) as a 32-bit binary angle.
// Depends on tlik_pkg; the pipeline advances only while en is high.
`timescale 1ns / 1ps

module tlik_cordic
    import tlik_pkg::*;
(
    input  logic                       aclk,
    input  logic                       en,
    input  logic signed [CORDIC_W-1:0] y_in,
    input  logic signed [CORDIC_W-1:0] x_in,
    output logic [31:0]                z_out
);

    logic signed [CORDIC_W-1:0] x_reg    [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] y_reg    [CORDIC_STEPS+1];
    logic [31:0]                z_reg    [CORDIC_STEPS+1];
    logic                       zero_reg [CORDIC_STEPS+1];

    // Fold the left half plane onto the right, then one micro-rotation per stage.
    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= (x_in == 0) && (y_in == 0);
            if (x_in < 0) begin
                x_reg[0] <= -x_in;
                y_reg[0] <= -y_in;
                z_reg[0] <= HALF_TURN;
            end else begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                z_reg[0] <= '0;
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin : step
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] > 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_entry(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_entry(i);
                end
            end
        end
    end

    // A vector of zero length has direction zero.
    assign z_out = zero_reg[CORDIC_STEPS] ? 32'h0 : z_reg[CORDIC_STEPS];

endmodule

>>> hdl/tlik_acos.sv
// Pipelined arccosine of num/den: restoring divider, square root and CORDIC.
// Depends on tlik_pkg and tlik_cordic; the pipeline advances only while en is high.
`timescale 1ns / 1ps

module tlik_acos
    import tlik_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic signed [33:0] num,
    input  logic [33:0]        den,
    output logic [31:0]        angle
);

    localparam int FLAG_LEN = ACOS_PRE + CORDIC_STEPS + 1;

    logic [33:0]          mag;
    logic [33:0]          rem_reg  [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] q_reg    [DIV_STEPS+1];
    logic [33:0]          den_reg  [DIV_STEPS+1];
    logic                 neg_reg  [DIV_STEPS+1];
    logic                 sat_reg  [DIV_STEPS+1];
    logic [FLAG_LEN-1:0]  dz_reg;

    logic [28:0]          qsat_reg;
    logic signed [29:0]   c30_reg;
    logic signed [29:0]   c31_reg;
    logic [57:0]          prod;
    logic [56:0]          csq_reg;

    logic [56:0]          sv_reg [SQ_STEPS+1];
    logic [57:0]          sr_reg [SQ_STEPS+1];
    logic signed [29:0]   sc_reg [SQ_STEPS+1];

    logic [28:0]          qsat_next;
    logic signed [29:0]   c_next;
    logic [31:0]          z;

    assign mag = num[33] ? 34'(-num) : 34'(num);

    // Restoring division, one quotient bit per stage; a ratio of one or more saturates.
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= mag;
            q_reg[0]   <= '0;
            den_reg[0] <= den;
            neg_reg[0] <= num[33];
            sat_reg[0] <= mag >= den;
            for (int i = 0; i < DIV_STEPS; i++) begin : div_step
                logic [33:0] rem2;
                rem2 = {rem_reg[i][32:0], 1'b0};
                den_reg[i+1] <= den_reg[i];
                neg_reg[i+1] <= neg_reg[i];
                sat_reg[i+1] <= sat_reg[i];
                if (rem2 >= den_reg[i]) begin
                    rem_reg[i+1] <= rem2 - den_reg[i];
                    q_reg[i+1]   <= {q_reg[i][DIV_STEPS-2:0], 1'b1};
                end else begin
                    rem_reg[i+1] <= rem2;
                    q_reg[i+1]   <= {q_reg[i][DIV_STEPS-2:0], 1'b0};
                end
            end
        end
    end

    // Zero-denominator flag rides along to the output.
    always_ff @(posedge aclk) begin
        if (en) begin
            dz_reg <= {dz_reg[FLAG_LEN-2:0], den == 34'd0};
        end
    end

    // Signed cosine in Q2.28, its square, and the sine argument 1 - c^2.
    assign qsat_next = sat_reg[DIV_STEPS] ? 29'h1000_0000 : {1'b0, q_reg[DIV_STEPS]};
    assign c_next    = neg_reg[DIV_STEPS] ? -$signed({1'b0, qsat_next})
                                          : $signed({1'b0, qsat_next});
    assign prod      = qsat_reg * qsat_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            qsat_reg  <= qsat_next;
            c30_reg   <= c_next;
            csq_reg   <= prod[56:0];
            c31_reg   <= c30_reg;
            sv_reg[0] <= (57'd1 << 56) - csq_reg;
            sr_reg[0] <= '0;
            sc_reg[0] <= c31_reg;
        end
    end

    // Square root of 1 - c^2, one result bit per stage.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < SQ_STEPS; k++) begin : sq_step
                logic [57:0] bitv;
                logic [57:0] trial;
                bitv  = 58'd1 << (56 - 2 * k);
                trial = sr_reg[k] + bitv;
                sc_reg[k+1] <= sc_reg[k];
                if ({1'b0, sv_reg[k]} >= trial) begin
                    sv_reg[k+1] <= sv_reg[k] - trial[56:0];
                    sr_reg[k+1] <= (sr_reg[k] >> 1) + bitv;
                end else begin
                    sv_reg[k+1] <= sv_reg[k];
                    sr_reg[k+1] <= sr_reg[k] >> 1;
                end
            end
        end
    end

    // acos(c) = atan2(sqrt(1 - c^2), c).
    tlik_cordic u_cordic (
        .aclk  (aclk),
        .en    (en),
        .y_in  ($signed({5'b0, sr_reg[SQ_STEPS][28:0]})),
        .x_in  ($signed({{4{sc_reg[SQ_STEPS][29]}}, sc_reg[SQ_STEPS]})),
        .z_out (z)
    );

    assign angle = dz_reg[FLAG_LEN-1] ? QUARTER_TURN : z;

endmodule

>>> hdl/two_link_ik_angle_solver.sv
// Two-link inverse kinematics solver: joint and target in, two absolute link angles out.
// Throughput: one beat per cycle; the whole pipeline advances unless the output stalls.
// Reset (aresetn low, synchronous) empties the pipeline and loads both lengths with 1600.
// Depends on tlik_pkg, tlik_acos, tlik_cordic and the assertion macro header.
`timescale 1ns / 1ps
`include "two_link_ik_angle_solver_macros.svh"

module two_link_ik_angle_solver
    import tlik_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration writes.
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [14:0] cfg_wdata,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // joint_x, joint_y, target_x, target_y
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // upper_angle, lower_angle
);

    logic                  en;
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [14:0]           upper_len_reg;
    logic [14:0]           lower_len_reg;

    logic signed [16:0]    dx_reg, dy_reg;
    logic signed [33:0]    sqx, sqy;
    logic [32:0]           sqx_reg, sqy_reg;
    logic [33:0]           dv_reg [DIST_STEPS+1];
    logic [34:0]           dr_reg [DIST_STEPS+1];
    logic [15:0]           sum_ab;
    logic [14:0]           lo;
    logic [16:0]           d_raw;
    logic [15:0]           dc_reg;
    logic [29:0]           aa_reg, bb_reg, ab_reg;
    logic [31:0]           dd_reg;
    logic [30:0]           ad_reg;
    logic signed [33:0]    num_a_reg, num_g_reg;
    logic [33:0]           den_a_reg, den_g_reg;
    logic [33:0]           dly_reg [THETA_DLY];
    logic [31:0]           theta, alpha, gamma;
    logic [31:0]           up, low, up_rnd, low_rnd;
    logic [31:0]           out_reg;

    // Whole pipeline moves when the output register is free or being taken.
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = valid_reg[PIPE_DEPTH-1];
    assign m_axis_tdata  = out_reg;

    // Valid bits and link lengths.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            upper_len_reg <= 15'd1600;
            lower_len_reg <= 15'd1600;
        end else begin
            if (en) begin
                valid_reg <= {valid_reg[PIPE_DEPTH-2:0], s_axis_tvalid};
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_UPPER: upper_len_reg <= cfg_wdata;
                    REG_LOWER: lower_len_reg <= cfg_wdata;
                    default:   upper_len_reg <= upper_len_reg;
                endcase
            end
        end
    end

    // Differences, their squares and the squared distance.
    assign sqx = dx_reg * dx_reg;
    assign sqy = dy_reg * dy_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg    <= $signed({s_axis_tdata[47], s_axis_tdata[47:32]})
                       - $signed({s_axis_tdata[15], s_axis_tdata[15:0]});
            dy_reg    <= $signed({s_axis_tdata[63], s_axis_tdata[63:48]})
                       - $signed({s_axis_tdata[31], s_axis_tdata[31:16]});
            sqx_reg   <= sqx[32:0];
            sqy_reg   <= sqy[32:0];
            dv_reg[0] <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
            dr_reg[0] <= '0;
        end
    end

    // Distance by digit-by-digit square root, one bit per stage.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < DIST_STEPS; k++) begin : dist_step
                logic [34:0] bitv;
                logic [34:0] trial;
                bitv  = 35'd1 << (32 - 2 * k);
                trial = dr_reg[k] + bitv;
                if ({1'b0, dv_reg[k]} >= trial) begin
                    dv_reg[k+1] <= dv_reg[k] - trial[33:0];
                    dr_reg[k+1] <= (dr_reg[k] >> 1) + bitv;
                end else begin
                    dv_reg[k+1] <= dv_reg[k];
                    dr_reg[k+1] <= dr_reg[k] >> 1;
                end
            end
        end
    end

    // Clamp the distance to the reachable ring, then form both cosine ratios.
    assign sum_ab = {1'b0, upper_len_reg} + {1'b0, lower_len_reg};
    assign lo     = (upper_len_reg > lower_len_reg) ? upper_len_reg - lower_len_reg
                                                    : lower_len_reg - upper_len_reg;
    assign d_raw  = dr_reg[DIST_STEPS][16:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (d_raw > {1'b0, sum_ab}) begin
                dc_reg <= sum_ab;
            end else if (d_raw < {2'b0, lo}) begin
                dc_reg <= {1'b0, lo};
            end else begin
                dc_reg <= d_raw[15:0];
            end
            aa_reg    <= upper_len_reg * upper_len_reg;
            bb_reg    <= lower_len_reg * lower_len_reg;
            ab_reg    <= upper_len_reg * lower_len_reg;
            dd_reg    <= dc_reg * dc_reg;
            ad_reg    <= upper_len_reg * dc_reg;
            num_a_reg <= $signed({4'b0, aa_reg}) + $signed({2'b0, dd_reg})
                       - $signed({4'b0, bb_reg});
            num_g_reg <= $signed({4'b0, aa_reg}) + $signed({4'b0, bb_reg})
                       - $signed({2'b0, dd_reg});
            den_a_reg <= {2'b0, ad_reg, 1'b0};
            den_g_reg <= {3'b0, ab_reg, 1'b0};
        end
    end

    // Interior angles.
    tlik_acos u_acos_alpha (
        .aclk  (aclk),
        .en    (en),
        .num   (num_a_reg),
        .den   (den_a_reg),
        .angle (alpha)
    );

    tlik_acos u_acos_gamma (
        .aclk  (aclk),
        .en    (en),
        .num   (num_g_reg),
        .den   (den_g_reg),
        .angle (gamma)
    );

    // Raw difference waits here so its direction is ready with the interior angles.
    always_ff @(posedge aclk) begin
        if (en) begin
            dly_reg[0] <= {dx_reg, dy_reg};
            for (int i = 1; i < THETA_DLY; i++) begin : theta_dly
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    tlik_cordic u_cordic_theta (
        .aclk  (aclk),
        .en    (en),
        .y_in  ($signed({{5{dly_reg[THETA_DLY-1][16]}}, dly_reg[THETA_DLY-1][16:0], 12'b0})),
        .x_in  ($signed({{5{dly_reg[THETA_DLY-1][33]}}, dly_reg[THETA_DLY-1][33:17], 12'b0})),
        .z_out (theta)
    );

    // Absolute link angles, rounded to 16-bit binary angles.
    assign up      = theta - alpha;
    assign low     = HALF_TURN + up - gamma;
    assign up_rnd  = up + 32'h0000_8000;
    assign low_rnd = low + 32'h0000_8000;

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= {low_rnd[31:16], up_rnd[31:16]};
        end
    end

    `TLIK_ASSERT_IMP(a_dist_clamped, aclk, aresetn, valid_reg[20], (dc_reg >= {1'b0, lo}) && (dc_reg <= sum_ab), "clamped distance outside reachable ring")
    `TLIK_ASSERT_IMP(a_stall_blocks_input, aclk, aresetn, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while output stalled")
    `TLIK_ASSERT_NXT(a_accept_enters, aclk, aresetn, s_axis_tvalid && s_axis_tready, valid_reg[0], "accepted beat lost at pipeline entry")

endmodule
